### design/mexp_pkg.sv
// shared constants and types for the modular exponentiation block
// no dependencies; used by mexp_modstep and modular_exponentiation

package mexp_pkg;

  // default operand width
  localparam int DEF_WIDTH = 63;

  // per-cycle control of the shared modular step unit
  typedef struct packed {
    logic add_en;  // add the b operand into the accumulator lane
    logic cin;     // bit shifted in at the bottom of the doubling lane
  } mexp_ctrl_t;

endpackage

### design/modular_exponentiation.sv
// modular exponentiation top level: square-and-multiply sequencer around one modular step unit
// depends on mexp_pkg and mexp_modstep
// exponent zero or modulus zero goes straight from idle to finish, skipping reduce and multiply;
//   a stalled output beat holds the sequencer in finish until m_tready
// throughput: one item at a time, s_tready high only while the sequencer is idle
// reset: synchronous active-high rst returns the sequencer to idle and drops m_tvalid

module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic clk,
  input  logic rst,
  // input beat: base, exponent, modulus from the lowest bit up, zero padded
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((3*WIDTH+7)/8)*8-1:0]        s_tdata,
  // result beat: result, zero padded
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((WIDTH+7)/8)*8-1:0]          m_tdata,
  // error: modulus was zero with a nonzero exponent
  output logic                                m_tuser
);

  localparam int OUT_W = ((WIDTH + 7) / 8) * 8;
  localparam int CW    = $clog2(WIDTH);

  typedef enum logic [2:0] {
    IDLE,    // waiting for an input beat
    REDUCE,  // base mod modulus, one base bit per cycle
    FIND,    // shift exponent up to its top set bit
    NEXT,    // decide: done, or square for the next exponent bit
    MUL,     // shift-and-add modular product, one multiplier bit per cycle
    FINISH   // hand the result to the output register
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] mod;       // modulus
  logic [WIDTH-1:0] bred;      // base reduced mod modulus
  logic [WIDTH-1:0] acc;       // running power
  logic [WIDTH-1:0] ma;        // multiplier, shifted right; base shifted left during reduce
  logic [WIDTH-1:0] mb;        // multiplicand, doubled each step; remainder during reduce
  logic [WIDTH-1:0] mp;        // partial product
  logic [WIDTH-1:0] ex;        // exponent, current bit at the top
  logic [CW-1:0]    cnt;       // bits left in reduce, exponent bits left afterwards
  logic             sq;        // current product is the squaring
  logic [WIDTH-1:0] res;       // finished result
  logic             err;       // finished error flag
  logic [WIDTH-1:0] res_out;   // output register
  logic             err_out;

  logic [WIDTH-1:0] in_base;
  logic [WIDTH-1:0] in_exp;
  logic [WIDTH-1:0] in_mod;

  mexp_ctrl_t       ctrl;
  logic [WIDTH-1:0] sum_out;
  logic [WIDTH-1:0] dbl_out;

  assign in_base = s_tdata[WIDTH-1:0];
  assign in_exp  = s_tdata[2*WIDTH-1:WIDTH];
  assign in_mod  = s_tdata[3*WIDTH-1:2*WIDTH];

  assign s_tready = (state == IDLE);
  assign m_tdata  = OUT_W'(res_out);
  assign m_tuser  = err_out;

  // multiply lane adds on a set multiplier bit; reduce feeds base bits msb first
  always_comb begin
    ctrl.add_en = (state == MUL) && ma[0];
    ctrl.cin    = (state == REDUCE) && ma[WIDTH-1];
  end

  mexp_modstep #(
    .WIDTH (WIDTH)
  ) u_step (
    .m       (mod),
    .acc     (mp),
    .b       (mb),
    .ctrl    (ctrl),
    .acc_out (sum_out),
    .dbl_out (dbl_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output register loads from finish and drains on m_tready
      if ((state == FINISH) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            mod <= in_mod;
            ex  <= in_exp;
            ma  <= in_base;
            mb  <= '0;
            cnt <= CW'(WIDTH - 1);
            if (in_exp == '0) begin
              // zero exponent gives 1 for any modulus
              res   <= WIDTH'(1);
              err   <= 1'b0;
              state <= FINISH;
            end else if (in_mod == '0) begin
              res   <= '0;
              err   <= 1'b1;
              state <= FINISH;
            end else begin
              err   <= 1'b0;
              state <= REDUCE;
            end
          end
        end

        REDUCE: begin
          // remainder = 2 * remainder + next base bit, reduced
          mb <= dbl_out;
          ma <= {ma[WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            bred  <= dbl_out;
            cnt   <= CW'(WIDTH - 1);
            state <= FIND;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        FIND: begin
          // top set bit seeds the power with the reduced base
          ex <= {ex[WIDTH-2:0], 1'b0};
          if (ex[WIDTH-1]) begin
            acc   <= bred;
            state <= NEXT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        NEXT: begin
          if (cnt == '0) begin
            res   <= acc;
            state <= FINISH;
          end else begin
            ma    <= acc;
            mb    <= acc;
            mp    <= '0;
            sq    <= 1'b1;
            state <= MUL;
          end
        end

        MUL: begin
          if (ma == '0) begin
            acc <= mp;
            if (sq && ex[WIDTH-1]) begin
              // set exponent bit: multiply the square by the reduced base
              ma <= mp;
              mb <= bred;
              mp <= '0;
              sq <= 1'b0;
            end else begin
              ex    <= {ex[WIDTH-2:0], 1'b0};
              cnt   <= cnt - 1'b1;
              state <= NEXT;
            end
          end else begin
            mp <= sum_out;
            mb <= dbl_out;
            ma <= {1'b0, ma[WIDTH-1:1]};
          end
        end

        FINISH: begin
          if (!m_tvalid || m_tready) begin
            res_out  <= res;
            err_out  <= err;
            state    <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // an error beat always carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (res_out == '0))
    else $error("error beat with nonzero result");

  // running power stays reduced between products
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == NEXT) |-> (acc < mod))
    else $error("running power not below modulus");

  // one item at a time: an accepted beat closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // a finished result is only handed over into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH) && m_tvalid && !m_tready |=> (state == FINISH))
    else $error("result overwrote a pending output beat");

endmodule

### design/mexp_modstep.sv
// shared modular step unit: one add-and-reduce lane and one double-and-reduce lane
// depends on mexp_pkg for the control struct

module mexp_modstep import mexp_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic [WIDTH-1:0] m,
  input  logic [WIDTH-1:0] acc,
  input  logic [WIDTH-1:0] b,
  input  mexp_ctrl_t       ctrl,
  output logic [WIDTH-1:0] acc_out,
  output logic [WIDTH-1:0] dbl_out
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] dbl;
  logic [WIDTH:0] m_ext;
  logic [WIDTH:0] sum_red;
  logic [WIDTH:0] dbl_red;

  // both operands below m, so one conditional subtract is enough
  always_comb begin
    m_ext = {1'b0, m};
    sum   = {1'b0, acc} + (ctrl.add_en ? {1'b0, b} : '0);
    dbl   = {b, ctrl.cin};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
  end

  assign acc_out = sum_red[WIDTH-1:0];
  assign dbl_out = dbl_red[WIDTH-1:0];

endmodule
